>>> rtl/sacf_pkg.sv
// Package for the set-associative cache lookup with FIFO replacement.
// Holds default geometry, result codes and the controller state types.
// No dependencies; every other file of the block but sacf_if imports it.
`default_nettype none

package sacf_pkg;

    // Default geometry
    localparam int SACF_LINE_BYTES  = 64;
    localparam int SACF_WAYS        = 4;
    localparam int SACF_CACHE_BYTES = 16384;
    localparam int SACF_ADDR_BITS   = 26;

    // Miss kind codes
    localparam logic [1:0] MISS_NONE    = 2'd0;
    localparam logic [1:0] MISS_FILL    = 2'd1;
    localparam logic [1:0] MISS_REPLACE = 2'd2;

    // Front end state (multi-cycle set/tag split)
    typedef enum logic [2:0] {
        FR_IDLE,
        FR_LINE,
        FR_QUOT,
        FR_REM,
        FR_PUSH
    } front_state_t;

    // Back end state
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOK
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/sacf_if.sv
// Channel interfaces of the cache lookup: address request and lookup result.
// Each carries valid, ready and its payload; depends on nothing else.
`default_nettype none

interface sacf_req_if #(
    parameter int ADDR_BITS = 26
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] byte_address;

    modport source (output valid, output byte_address, input ready);
    modport sink   (input valid, input byte_address, output ready);
endinterface

interface sacf_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [1:0] miss_kind;

    modport source (output valid, output hit, output miss_kind, input ready);
    modport sink   (input valid, input hit, input miss_kind, output ready);
endinterface

`default_nettype wire

>>> rtl/sacf_front.sv
// Front end: accepts byte addresses and splits them into set index and tag.
// Uses sacf_pkg and sacf_req_if; feeds the request queue.
`default_nettype none

module sacf_front #(
    parameter int ADDR_BITS  = 26,
    parameter int LINE_BYTES = 64,
    parameter int OFF_W      = 6,
    parameter int LINE_NO_W  = 20,
    parameter int NUM_SETS   = 64,
    parameter int SET_W      = 6,
    parameter int TAG_W      = 14
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    sacf_req_if.sink                    req,
    input  wire logic                   hold,
    output logic                        push_valid,
    input  wire logic                   push_ready,
    output logic [SET_W+TAG_W-1:0]      push_data
);
    import sacf_pkg::*;

    localparam bit SETS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
    localparam bit LINE_POW2 = ((LINE_BYTES & (LINE_BYTES - 1)) == 0);

    generate
        if (LINE_POW2 && (NUM_SETS == 1)) begin : g_one_set
            logic [LINE_NO_W-1:0] line_no;

            // Single set: the whole line number is the tag
            assign line_no    = req.byte_address[ADDR_BITS-1:OFF_W];
            assign push_valid = req.valid && !hold;
            assign req.ready  = push_ready && !hold;
            assign push_data  = {SET_W'(0), line_no[TAG_W-1:0]};
        end else if (LINE_POW2 && SETS_POW2) begin : g_pow2
            logic [LINE_NO_W-1:0] line_no;

            // Power-of-two set count: set index is a bit field
            assign line_no    = req.byte_address[ADDR_BITS-1:OFF_W];
            assign push_valid = req.valid && !hold;
            assign req.ready  = push_ready && !hold;
            assign push_data  = {line_no[SET_W-1:0], line_no[LINE_NO_W-1 -: TAG_W]};
        end else begin : g_div
            // Reciprocal constants: floor(x / d) == (x * M) >> S for every x
            // below 2**n, with S = n + clog2(d) and M = ceil(2**S / d)
            localparam int          LINE_S = ADDR_BITS + $clog2(LINE_BYTES);
            localparam int          SET_S  = LINE_NO_W + $clog2(NUM_SETS);
            localparam logic [63:0] LINE_M =
                ((64'd1 << LINE_S) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES);
            localparam logic [63:0] SET_M  =
                ((64'd1 << SET_S) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
            localparam int          LP_W   = 2 * ADDR_BITS + 1;
            localparam int          SP_W   = 2 * LINE_NO_W + 1;
            localparam int          QN_W   = TAG_W + SET_W + 1;

            front_state_t         state_reg, state_next;
            logic [ADDR_BITS-1:0] addr_reg, addr_next;
            logic [LINE_NO_W-1:0] line_reg, line_next;
            logic [TAG_W-1:0]     quot_reg, quot_next;
            logic [SET_W-1:0]     rem_reg, rem_next;
            logic [LP_W-1:0]      line_prod;
            logic [SP_W-1:0]      set_prod;
            logic [QN_W-1:0]      quot_times_n;

            // One constant multiply per step: line number, tag, then set index
            assign line_prod    = LP_W'(addr_reg) * LP_W'(LINE_M);
            assign set_prod     = SP_W'(line_reg) * SP_W'(SET_M);
            assign quot_times_n = QN_W'(quot_reg) * QN_W'(NUM_SETS);

            // Next state
            always_comb
            begin
                state_next = state_reg;
                unique case (state_reg)
                    FR_IDLE:
                    begin
                        if (req.valid && !hold)
                        begin
                            state_next = FR_LINE;
                        end
                    end
                    FR_LINE:
                    begin
                        state_next = FR_QUOT;
                    end
                    FR_QUOT:
                    begin
                        state_next = FR_REM;
                    end
                    FR_REM:
                    begin
                        state_next = FR_PUSH;
                    end
                    FR_PUSH:
                    begin
                        if (push_ready)
                        begin
                            state_next = FR_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = FR_IDLE;
                    end
                endcase
            end

            // Outputs and datapath
            always_comb
            begin
                req.ready  = 1'b0;
                push_valid = 1'b0;
                addr_next  = addr_reg;
                line_next  = line_reg;
                quot_next  = quot_reg;
                rem_next   = rem_reg;
                unique case (state_reg)
                    FR_IDLE:
                    begin
                        req.ready = !hold;
                        addr_next = req.byte_address;
                    end
                    FR_LINE:
                    begin
                        line_next = LINE_NO_W'(line_prod >> LINE_S);
                    end
                    FR_QUOT:
                    begin
                        quot_next = TAG_W'(set_prod >> SET_S);
                    end
                    FR_REM:
                    begin
                        rem_next = SET_W'(line_reg - LINE_NO_W'(quot_times_n));
                    end
                    FR_PUSH:
                    begin
                        push_valid = 1'b1;
                    end
                    default:
                    begin
                        req.ready = 1'b0;
                    end
                endcase
            end

            assign push_data = {rem_reg, quot_reg};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    state_reg <= FR_IDLE;
                end
                else
                begin
                    state_reg <= state_next;
                end
            end

            // Payload: address, line number, quotient and remainder
            always_ff @(posedge clk)
            begin
                addr_reg <= addr_next;
                line_reg <= line_next;
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
            end
        end
    endgenerate

endmodule

`default_nettype wire

>>> rtl/sacf_queue.sv
// Two-entry queue between front and back end of the cache lookup.
// Holds split {set, tag} requests; uses sacf_pkg only by convention.
`default_nettype none

module sacf_queue #(
    parameter int WIDTH = 20
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    import sacf_pkg::*;

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sacf_back.sv
// Back end: reads a set's tags and state, decides hit/fill/replace, writes back on a miss.
// Owns the tag and line-state memories; uses sacf_pkg and sacf_rsp_if.
`default_nettype none

module sacf_back #(
    parameter int NUM_SETS = 64,
    parameter int SET_W    = 6,
    parameter int TAG_W    = 14,
    parameter int WAYS     = 4,
    parameter int WAY_W    = 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pop_valid,
    output logic                        pop_ready,
    input  wire logic [SET_W+TAG_W-1:0] pop_data,
    output logic                        clearing,
    sacf_rsp_if.source                  rsp
);
    import sacf_pkg::*;

    localparam int META_W = WAY_W + WAYS;

    // Per set: {oldest way pointer, valid bits}; and all tags of the set
    logic [META_W-1:0]     meta_mem [NUM_SETS];
    logic [WAYS*TAG_W-1:0] tag_mem  [NUM_SETS];

    back_state_t           state_reg, state_next;
    logic [SET_W-1:0]      clr_reg;
    logic [META_W-1:0]     meta_rd_reg;
    logic [WAYS*TAG_W-1:0] tag_rd_reg;
    logic [SET_W-1:0]      set_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  hit_reg;
    logic [1:0]            kind_reg;

    logic                  rd_en;
    logic                  update;
    logic                  slot_free;
    logic [SET_W-1:0]      pop_set;
    logic [TAG_W-1:0]      pop_tag;
    logic [WAYS-1:0]       valid_v;
    logic [WAY_W-1:0]      ptr;
    logic                  hit_any;
    logic                  free_found;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      victim;
    logic [WAY_W-1:0]      ptr_new;
    logic [WAYS-1:0]       valid_new;
    logic [WAYS*TAG_W-1:0] tags_new;
    logic                  meta_we;
    logic                  tag_we;
    logic [SET_W-1:0]      wr_set;
    logic [META_W-1:0]     meta_wdata;

    assign pop_set   = pop_data[SET_W+TAG_W-1:TAG_W];
    assign pop_tag   = pop_data[TAG_W-1:0];
    assign slot_free = !out_valid_reg || rsp.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                if (clr_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = BK_LOOK;
                end
            end
            BK_LOOK:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        clearing  = 1'b0;
        pop_ready = 1'b0;
        update    = 1'b0;
        unique case (state_reg)
            BK_CLEAR: clearing  = 1'b1;
            BK_IDLE:  pop_ready = 1'b1;
            BK_LOOK:  update    = slot_free;
            default:  clearing  = 1'b0;
        endcase
    end

    assign rd_en = pop_valid && pop_ready;

    // Compare all ways and pick the victim
    always_comb
    begin
        valid_v    = meta_rd_reg[WAYS-1:0];
        ptr        = meta_rd_reg[META_W-1:WAYS];
        hit_any    = 1'b0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (valid_v[w] && (tag_rd_reg[w*TAG_W +: TAG_W] == tag_reg))
            begin
                hit_any = 1'b1;
            end
        end
        // Lowest-numbered invalid way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!valid_v[w])
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end
        victim  = free_found ? free_way : ptr;
        if (free_found)
        begin
            ptr_new = ptr;
        end
        else if (ptr == WAY_W'(WAYS - 1))
        begin
            ptr_new = '0;
        end
        else
        begin
            ptr_new = ptr + WAY_W'(1);
        end
        valid_new = valid_v;
        tags_new  = tag_rd_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == victim)
            begin
                valid_new[w]              = 1'b1;
                tags_new[w*TAG_W +: TAG_W] = tag_reg;
            end
        end
    end

    // Memory write port: clearing pass or miss update
    always_comb
    begin
        meta_we    = clearing || (update && !hit_any);
        tag_we     = update && !hit_any;
        wr_set     = clearing ? clr_reg : set_reg;
        meta_wdata = clearing ? '0 : {ptr_new, valid_new};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (update)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + SET_W'(1);
            end
        end
    end

    // Memories: registered read at pop, single write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            meta_rd_reg <= meta_mem[pop_set];
            tag_rd_reg  <= tag_mem[pop_set];
        end
        if (meta_we)
        begin
            meta_mem[wr_set] <= meta_wdata;
        end
        if (tag_we)
        begin
            tag_mem[wr_set] <= tags_new;
        end
    end

    // Hold request fields and result payload
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            set_reg <= pop_set;
            tag_reg <= pop_tag;
        end
        if (update)
        begin
            hit_reg  <= hit_any;
            kind_reg <= hit_any ? MISS_NONE : (free_found ? MISS_FILL : MISS_REPLACE);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = hit_reg;
    assign rsp.miss_kind = kind_reg;

endmodule

`default_nettype wire

>>> rtl/set_assoc_cache_fifo_lookup.sv
// Set-associative cache tag lookup with FIFO (round-robin) replacement.
// An address passes the two-entry queue, the back end's set-row read registers
// and the result register; the split first steps it through its line, quotient,
// remainder and push states unless LINE_BYTES and the set count are powers of
// two. The back end takes one request at a time and holds it while the last
// result waits. Reset: a clearing pass over all NUM_SETS sets (64 by default)
// zeroes valid bits and replacement pointers; no address is taken during it.
`default_nettype none

module set_assoc_cache_fifo_lookup #(
    parameter int LINE_BYTES  = sacf_pkg::SACF_LINE_BYTES,
    parameter int WAYS        = sacf_pkg::SACF_WAYS,
    parameter int CACHE_BYTES = sacf_pkg::SACF_CACHE_BYTES,
    parameter int ADDR_BITS   = sacf_pkg::SACF_ADDR_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sacf_req_if.sink    req,
    sacf_rsp_if.source  rsp
);
    import sacf_pkg::*;

    localparam int OFF_W     = $clog2(LINE_BYTES + 1) - 1;
    localparam int LINE_NO_W = ADDR_BITS - OFF_W;
    localparam int RAW_SETS  = CACHE_BYTES / (LINE_BYTES * WAYS);
    localparam int NUM_SETS  = (RAW_SETS > 0) ? RAW_SETS : 1;
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int TAG_RAW_W = LINE_NO_W - $clog2(NUM_SETS + 1) + 1;
    localparam int TAG_W     = (TAG_RAW_W > 0) ? TAG_RAW_W : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int Q_W       = SET_W + TAG_W;

    logic           push_valid, push_ready;
    logic [Q_W-1:0] push_data;
    logic           pop_valid, pop_ready;
    logic [Q_W-1:0] pop_data;
    logic           clearing;

    sacf_front #(
        .ADDR_BITS  (ADDR_BITS),
        .LINE_BYTES (LINE_BYTES),
        .OFF_W      (OFF_W),
        .LINE_NO_W  (LINE_NO_W),
        .NUM_SETS   (NUM_SETS),
        .SET_W      (SET_W),
        .TAG_W      (TAG_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .hold       (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sacf_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sacf_back #(
        .NUM_SETS (NUM_SETS),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W),
        .WAYS     (WAYS),
        .WAY_W    (WAY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .clearing  (clearing),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
